/* src/lmc_pkg.sv */
// Shared types and constants of the local minimum counter.
`timescale 1ns / 1ps
`default_nettype none

package lmc_pkg;

    // Configuration port
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 9;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COLUMN_COUNT = 2'd1;

    // Result counter
    localparam int                     COUNT_WIDTH = 17;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = '1;

    // Per-cell control of the line chain
    typedef struct packed {
        logic shift;   // advance the chain by one entry
        logic load;    // this cell is the entry point of the chain
        logic kill;    // drop the candidate flag on its way out of this cell
    } lmc_cell_ctrl_t;

endpackage

`default_nettype wire

/* src/local_minimum_counter_core.sv */
// Top level: raster-order local minimum counter with a chained line buffer.
`timescale 1ns / 1ps
`default_nettype none

// Counts strict local minima (8-neighborhood) of a matrix streamed in raster
// order; a cell with no neighbors counts. The frame size comes from two
// registers (row count, column count; 0 acts as 1, values above MAX_ROWS or
// MAX_COLUMNS act as that maximum), and any write to either restarts the
// frame. The block takes one value every clock cycle unless a result waits
// untaken, with no clearing pass after reset; the rate is set by the single
// compare-and-shift step through the line chain, a row of MAX_COLUMNS cells
// advancing by one entry per accepted request. A frame's count saturates at
// 17 bits and is on the result channel the cycle after its last value is in.
module local_minimum_counter_core
    import lmc_pkg::*;
#(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 256,
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // configuration writes
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    // value stream
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [VALUE_WIDTH-1:0]     s_cell_value,
    // frame results
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic      [COUNT_WIDTH-1:0]     m_minimum_count
);

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int UL_IDX = MAX_COLUMNS - 1;
    localparam int UP_IDX = MAX_COLUMNS - 2;
    localparam int UR_IDX = (MAX_COLUMNS >= 3) ? MAX_COLUMNS - 3 : 0;
    localparam bit HAS_UR = (MAX_COLUMNS >= 3);

    // Size registers, held as size minus one after clamping
    logic [COL_W-1:0] cols_m1_reg;
    logic [ROW_W-1:0] rows_m1_reg;
    logic [COL_W-1:0] cols_m1_next;
    logic [ROW_W-1:0] rows_m1_next;
    logic [31:0]      cfg_data_ext;
    logic             cfg_write;
    logic             cfg_hit;

    // Frame position and count
    logic [COL_W-1:0]       col_pos_reg;
    logic [ROW_W-1:0]       row_pos_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COL_W-1:0]       col_pos_next;
    logic [ROW_W-1:0]       row_pos_next;
    logic [COUNT_WIDTH-1:0] count_next;

    // Most recent entry, one step ahead of the chain
    logic [VALUE_WIDTH-1:0] l_value_reg;
    logic                   l_flag_reg;

    // Result register
    logic                   m_valid_reg;
    logic [COUNT_WIDTH-1:0] m_minimum_count_reg;

    // Chain
    lmc_cell_ctrl_t         cell_ctrl  [MAX_COLUMNS];
    logic [VALUE_WIDTH-1:0] cell_value [MAX_COLUMNS];
    logic                   cell_flag  [MAX_COLUMNS];

    logic accept;
    logic last_col;
    logic last_row;
    logic frame_end;
    logic cols_is1;
    logic ur_from_l;
    logic en_left;
    logic en_ul;
    logic en_up;
    logic en_ur;

    logic [VALUE_WIDTH-1:0] up_value;
    logic                   up_flag_in;
    logic [VALUE_WIDTH-1:0] ur_value;
    logic                   kill_left;
    logic                   kill_ul;
    logic                   kill_up;
    logic                   kill_ur;
    logic                   cur_flag;
    logic                   left_flag_mod;
    logic                   up_flag_mod;
    logic                   ul_flag_mod;
    logic [2:0]             tally;
    logic [COUNT_WIDTH:0]   count_sum;
    logic [COUNT_WIDTH-1:0] count_sat;

    assign cfg_ready = 1'b1;
    assign s_ready   = ~m_valid_reg | m_ready;
    assign accept    = s_valid & s_ready;
    assign cfg_write = cfg_valid & cfg_ready;

    assign m_valid         = m_valid_reg;
    assign m_minimum_count = m_minimum_count_reg;

    // Decode and clamp configuration writes
    always_comb begin
        cfg_data_ext = 32'(cfg_data);
        cols_m1_next = cols_m1_reg;
        rows_m1_next = rows_m1_reg;
        cfg_hit      = 1'b0;
        unique case (cfg_index)
            REG_ROW_COUNT: begin
                cfg_hit = 1'b1;
                if (cfg_data_ext == 32'd0) begin
                    rows_m1_next = '0;
                end else if (cfg_data_ext > 32'(MAX_ROWS)) begin
                    rows_m1_next = ROW_W'(MAX_ROWS - 1);
                end else begin
                    rows_m1_next = ROW_W'(cfg_data_ext - 32'd1);
                end
            end
            REG_COLUMN_COUNT: begin
                cfg_hit = 1'b1;
                if (cfg_data_ext == 32'd0) begin
                    cols_m1_next = '0;
                end else if (cfg_data_ext > 32'(MAX_COLUMNS)) begin
                    cols_m1_next = COL_W'(MAX_COLUMNS - 1);
                end else begin
                    cols_m1_next = COL_W'(cfg_data_ext - 32'd1);
                end
            end
            default: begin
                cfg_hit = 1'b0;
            end
        endcase
    end

    assign last_col  = (col_pos_reg == cols_m1_reg);
    assign last_row  = (row_pos_reg == rows_m1_reg);
    assign frame_end = last_col & last_row;
    assign cols_is1  = (cols_m1_reg == COL_W'(0));
    assign ur_from_l = (cols_m1_reg == COL_W'(1)) | ~HAS_UR;

    // Neighbors that exist for this position
    assign en_left = (col_pos_reg != '0);
    assign en_up   = (row_pos_reg != '0);
    assign en_ul   = en_up & en_left;
    assign en_ur   = en_up & ~last_col;

    // Pick taps; narrow rows alias the upper neighbors onto the newest entry
    assign up_value   = cols_is1  ? l_value_reg : cell_value[UP_IDX];
    assign up_flag_in = cols_is1  ? l_flag_reg  : cell_flag[UP_IDX];
    assign ur_value   = ur_from_l ? l_value_reg : cell_value[UR_IDX];

    // Compare with each neighbor; the larger or equal side loses candidacy
    always_comb begin
        kill_left = en_left & ($signed(l_value_reg) >= $signed(s_cell_value));
        kill_ul   = en_ul & ($signed(cell_value[UL_IDX]) >= $signed(s_cell_value));
        kill_up   = en_up & ($signed(up_value) >= $signed(s_cell_value));
        kill_ur   = en_ur & ($signed(ur_value) >= $signed(s_cell_value));
        cur_flag  = ~(en_left & ($signed(s_cell_value) >= $signed(l_value_reg)))
                  & ~(en_ul & ($signed(s_cell_value) >= $signed(cell_value[UL_IDX])))
                  & ~(en_up & ($signed(s_cell_value) >= $signed(up_value)))
                  & ~(en_ur & ($signed(s_cell_value) >= $signed(ur_value)));
        left_flag_mod = l_flag_reg & ~kill_left & ~(ur_from_l & kill_ur)
                      & ~(cols_is1 & kill_up);
        up_flag_mod   = up_flag_in & ~(cols_is1 & kill_up);
        ul_flag_mod   = cell_flag[UL_IDX];
    end

    // Count cells whose last neighbor has just arrived
    always_comb begin
        tally = 3'(en_ul & ul_flag_mod)
              + 3'(en_up & last_col & up_flag_mod)
              + 3'(last_row & en_left & left_flag_mod)
              + 3'(last_row & last_col & cur_flag);
        count_sum = {1'b0, count_reg} + (COUNT_WIDTH + 1)'(tally);
        count_sat = count_sum[COUNT_WIDTH] ? COUNT_MAX : count_sum[COUNT_WIDTH-1:0];
    end

    // Advance position and count
    always_comb begin
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        count_next   = count_reg;
        if (cfg_write && cfg_hit) begin
            col_pos_next = '0;
            row_pos_next = '0;
            count_next   = '0;
        end else if (accept) begin
            if (!last_col) begin
                col_pos_next = col_pos_reg + COL_W'(1);
                count_next   = count_sat;
            end else if (!last_row) begin
                col_pos_next = '0;
                row_pos_next = row_pos_reg + ROW_W'(1);
                count_next   = count_sat;
            end else begin
                col_pos_next = '0;
                row_pos_next = '0;
                count_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_m1_reg <= '0;
            rows_m1_reg <= '0;
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            count_reg   <= '0;
            l_flag_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_write) begin
                cols_m1_reg <= cols_m1_next;
                rows_m1_reg <= rows_m1_next;
            end
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
            count_reg   <= count_next;
            if (accept) begin
                l_flag_reg <= cur_flag;
            end
            // Hold the result until taken
            if (accept && frame_end) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            l_value_reg <= s_cell_value;
        end
        if (accept && frame_end) begin
            m_minimum_count_reg <= count_sat;
        end
    end

    // Line chain: the newest entry enters where a row's length before the end
    for (genvar k = 0; k < MAX_COLUMNS; k++) begin : g_chain
        logic [VALUE_WIDTH-1:0] prev_value;
        logic                   prev_flag;

        if (k == 0) begin : g_head
            assign prev_value = l_value_reg;
            assign prev_flag  = left_flag_mod;
        end else begin : g_link
            assign prev_value = cell_value[k-1];
            assign prev_flag  = cell_flag[k-1];
        end

        always_comb begin
            cell_ctrl[k].shift = accept;
            cell_ctrl[k].load  = (cols_m1_reg == COL_W'(MAX_COLUMNS - 1 - k));
            cell_ctrl[k].kill  = ((k == UL_IDX) && kill_ul)
                               | ((k == UP_IDX) && kill_up && !cols_is1)
                               | (HAS_UR && (k == UR_IDX) && kill_ur && !ur_from_l);
        end

        lmc_cell #(
            .VALUE_WIDTH(VALUE_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl[k]),
            .ins_value (l_value_reg),
            .ins_flag  (left_flag_mod),
            .prev_value(prev_value),
            .prev_flag (prev_flag),
            .out_value (cell_value[k]),
            .out_flag  (cell_flag[k])
        );
    end

    // Position stays inside the configured frame
    a_col_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        col_pos_reg <= cols_m1_reg)
        else $error("column position beyond configured width");

    a_row_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        row_pos_reg <= rows_m1_reg)
        else $error("row position beyond configured height");

    // A frame's last value yields a result and rewinds the frame
    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && frame_end |=> m_valid_reg && col_pos_reg == '0
                                && row_pos_reg == '0 && count_reg == '0)
        else $error("frame end did not post a result and restart");

    // A result is never overwritten before it is taken
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !accept)
        else $error("request accepted while result stalled");

endmodule

`default_nettype wire

/* src/lmc_cell.sv */
// One cell of the line chain: holds one earlier value and its candidate flag.
`timescale 1ns / 1ps
`default_nettype none

module lmc_cell
    import lmc_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic                   aclk,
    input  wire lmc_cell_ctrl_t         ctrl,
    input  wire logic [VALUE_WIDTH-1:0] ins_value,
    input  wire logic                   ins_flag,
    input  wire logic [VALUE_WIDTH-1:0] prev_value,
    input  wire logic                   prev_flag,
    output logic      [VALUE_WIDTH-1:0] out_value,
    output logic                        out_flag
);

    logic [VALUE_WIDTH-1:0] value_reg;
    logic                   flag_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic                   flag_next;

    // Take the new entry at the entry point, otherwise the neighbor's
    always_comb begin
        value_next = ctrl.load ? ins_value : prev_value;
        flag_next  = ctrl.load ? ins_flag  : prev_flag;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            value_reg <= value_next;
            flag_reg  <= flag_next;
        end
    end

    // Hand the flag on with the current compare result applied
    assign out_value = value_reg;
    assign out_flag  = flag_reg & ~ctrl.kill;

endmodule

`default_nettype wire
